// ===== rtl/scl_pkg.sv =====
package scl_pkg;

    // characters with a meaning to the lexer
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;

    // result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one result beat
    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       token_end;
        logic       line_end;
        logic       last;
    } result_t;

    // results produced by one item, handed to the queue
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

// ===== rtl/scl_lexer.sv =====
module scl_lexer
    import scl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [7:0] item_byte,
    input  logic       item_eoi,
    output push_t      push
);

    logic       sq_reg, sq_next;
    logic       dq_reg, dq_next;
    logic       esc_reg, esc_next;
    logic       cmt_reg, cmt_next;
    logic       word_reg, word_next;
    logic       op_reg, op_next;
    logic [7:0] op_byte_reg, op_byte_next;

    function automatic result_t mk(input logic [7:0] ch, input logic has,
                                   input logic te, input logic le);
        result_t r;
        r.out_char  = has ? ch : 8'h00;
        r.has_char  = has;
        r.token_end = te;
        r.line_end  = le;
        r.last      = 1'b0;
        return r;
    endfunction

    // lexer decision for the item in the input register
    always_comb
    begin
        logic       is_nl;
        result_t    r0;
        result_t    r1;
        logic [1:0] n;
        logic       end_line;
        is_nl        = (item_byte == CH_NEWLINE);
        r0           = '0;
        r1           = '0;
        n            = 2'd0;
        end_line     = 1'b0;
        sq_next      = sq_reg;
        dq_next      = dq_reg;
        esc_next     = esc_reg;
        cmt_next     = cmt_reg;
        word_next    = word_reg;
        op_next      = op_reg;
        op_byte_next = op_byte_reg;

        if (item_eoi)
        begin
            end_line = 1'b1;
        end
        else if (cmt_reg)
        begin
            end_line = is_nl;
        end
        else if (esc_reg)
        begin
            esc_next  = 1'b0;
            word_next = 1'b1;
            r0        = mk(item_byte, 1'b1, 1'b0, 1'b0);
            n         = 2'd1;
        end
        else if (sq_reg)
        begin
            if (item_byte == CH_SQUOTE)
            begin
                sq_next = 1'b0;
            end
            else
            begin
                word_next = 1'b1;
                r0        = mk(item_byte, 1'b1, 1'b0, 1'b0);
                n         = 2'd1;
            end
        end
        else if (dq_reg)
        begin
            if (item_byte == CH_DQUOTE)
            begin
                dq_next = 1'b0;
            end
            else if (item_byte == CH_BSLASH)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                word_next = 1'b1;
                r0        = mk(item_byte, 1'b1, 1'b0, 1'b0);
                n         = 2'd1;
            end
        end
        else if (is_nl)
        begin
            end_line = 1'b1;
        end
        else if (item_byte == CH_HASH && !word_reg && !op_reg)
        begin
            cmt_next = 1'b1;
        end
        else if (item_byte inside {CH_BSLASH, CH_SQUOTE, CH_DQUOTE})
        begin
            // held operator goes out before the quote or escape
            if (op_reg)
            begin
                r0           = mk(op_byte_reg, 1'b1, 1'b1, 1'b0);
                n            = 2'd1;
                op_next      = 1'b0;
                op_byte_next = 8'h00;
            end
            esc_next = (item_byte == CH_BSLASH);
            sq_next  = (item_byte == CH_SQUOTE);
            dq_next  = (item_byte == CH_DQUOTE);
        end
        else if (item_byte inside {CH_SPACE, CH_TAB})
        begin
            if (op_reg)
            begin
                r0           = mk(op_byte_reg, 1'b1, 1'b1, 1'b0);
                n            = 2'd1;
                op_next      = 1'b0;
                op_byte_next = 8'h00;
            end
            else if (word_reg)
            begin
                r0        = mk(8'h00, 1'b0, 1'b1, 1'b0);
                n         = 2'd1;
                word_next = 1'b0;
            end
        end
        else if (item_byte inside {CH_SEMI, CH_LT, CH_LPAREN, CH_RPAREN})
        begin
            if (op_reg)
            begin
                r0           = mk(op_byte_reg, 1'b1, 1'b1, 1'b0);
                r1           = mk(item_byte, 1'b1, 1'b1, 1'b0);
                n            = 2'd2;
                op_next      = 1'b0;
                op_byte_next = 8'h00;
            end
            else if (word_reg)
            begin
                r0        = mk(8'h00, 1'b0, 1'b1, 1'b0);
                r1        = mk(item_byte, 1'b1, 1'b1, 1'b0);
                n         = 2'd2;
                word_next = 1'b0;
            end
            else
            begin
                r0 = mk(item_byte, 1'b1, 1'b1, 1'b0);
                n  = 2'd1;
            end
        end
        else if (item_byte inside {CH_PIPE, CH_AMP, CH_GT})
        begin
            if (op_reg)
            begin
                // second byte joins into a two-byte operator
                r0           = mk(op_byte_reg, 1'b1, 1'b0, 1'b0);
                r1           = mk(item_byte, 1'b1, 1'b1, 1'b0);
                n            = 2'd2;
                op_next      = 1'b0;
                op_byte_next = 8'h00;
            end
            else
            begin
                if (word_reg)
                begin
                    r0        = mk(8'h00, 1'b0, 1'b1, 1'b0);
                    n         = 2'd1;
                    word_next = 1'b0;
                end
                op_next      = 1'b1;
                op_byte_next = item_byte;
            end
        end
        else
        begin
            // plain word byte, after any held operator
            word_next = 1'b1;
            if (op_reg)
            begin
                r0           = mk(op_byte_reg, 1'b1, 1'b1, 1'b0);
                r1           = mk(item_byte, 1'b1, 1'b0, 1'b0);
                n            = 2'd2;
                op_next      = 1'b0;
                op_byte_next = 8'h00;
            end
            else
            begin
                r0 = mk(item_byte, 1'b1, 1'b0, 1'b0);
                n  = 2'd1;
            end
        end

        // line end closes whatever is open and clears all state
        if (end_line)
        begin
            if (op_reg)
            begin
                r0 = mk(op_byte_reg, 1'b1, 1'b1, 1'b1);
            end
            else if (word_reg)
            begin
                r0 = mk(8'h00, 1'b0, 1'b1, 1'b1);
            end
            else
            begin
                r0 = mk(8'h00, 1'b0, 1'b0, 1'b1);
            end
            n            = 2'd1;
            sq_next      = 1'b0;
            dq_next      = 1'b0;
            esc_next     = 1'b0;
            cmt_next     = 1'b0;
            word_next    = 1'b0;
            op_next      = 1'b0;
            op_byte_next = 8'h00;
        end

        // mark the final result of the item
        if (n == 2'd1)
        begin
            r0.last = 1'b1;
        end
        if (n == 2'd2)
        begin
            r1.last = 1'b1;
        end

        push.cnt = item_valid ? n : 2'd0;
        push.r0  = r0;
        push.r1  = r1;
    end

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg      <= 1'b0;
            dq_reg      <= 1'b0;
            esc_reg     <= 1'b0;
            cmt_reg     <= 1'b0;
            word_reg    <= 1'b0;
            op_reg      <= 1'b0;
            op_byte_reg <= 8'h00;
        end
        else if (item_valid)
        begin
            sq_reg      <= sq_next;
            dq_reg      <= dq_next;
            esc_reg     <= esc_next;
            cmt_reg     <= cmt_next;
            word_reg    <= word_next;
            op_reg      <= op_next;
            op_byte_reg <= op_byte_next;
        end
    end

endmodule

// ===== rtl/scl_result_fifo.sv =====
module scl_result_fifo
    import scl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t head
);

    result_t                entries [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]      count_reg, count_next;
    logic                   pop;

    // room for the two results an item may bring
    assign room      = (count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop);
        count_next  = count_reg + (QUEUE_AW+1)'(push.cnt) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage, one or two beats written per item
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            entries[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2)
        begin
            entries[wr_ptr_reg + QUEUE_AW'(1)] <= push.r1;
        end
    end

endmodule

// ===== rtl/shell_command_lexer.sv =====
// channel | signals                                          | direction
// input   | in_valid, in_stall, byte_in, end_of_input        | byte stream in
// output  | out_valid, out_stall, out_char, has_char,        | token beats out
//         | token_end, line_end, last                        |
//
// one input beat per cycle unless in_stall is high; a taken beat waits in
// the input register until the queue has room, is then lexed and queued
// a beat that makes two results costs the queue one extra slot; input stalls
// only while the four-entry result queue has fewer than two free slots
// reset clears the lexer state, the input register and the result queue
// a stalled output holds its beat; input keeps flowing until the queue lacks room
module shell_command_lexer
    import scl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       has_char,
    output logic       token_end,
    output logic       line_end,
    output logic       last
);

    logic       item_reg, item_next;
    logic [7:0] byte_reg;
    logic       eoi_reg;
    logic       room;
    logic       consume;
    push_t      push;
    result_t    head;

    // input register advances when the queue can take two results
    assign consume   = item_reg && room;
    assign in_stall  = item_reg && !room;
    assign item_next = (in_valid && !in_stall) ? 1'b1 : (consume ? 1'b0 : item_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= 1'b0;
        end
        else
        begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= byte_in;
            eoi_reg  <= end_of_input;
        end
    end

    scl_lexer u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (consume),
        .item_byte  (byte_reg),
        .item_eoi   (eoi_reg),
        .push       (push)
    );

    scl_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    // result beat fields
    assign out_char  = head.out_char;
    assign has_char  = head.has_char;
    assign token_end = head.token_end;
    assign line_end  = head.line_end;
    assign last      = head.last;

endmodule

// ===== rtl/scl_checker.sv =====
module scl_checker
    import scl_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_char,
    input logic       has_char,
    input logic       token_end,
    input logic       line_end,
    input logic       last
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(has_char)
            && $stable(token_end) && $stable(line_end) && $stable(last))
        else $error("output beat changed while stalled");

    // a beat with no character carries a zero byte
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_char |-> out_char == 8'h00)
        else $error("out_char not zero without has_char");

    // a line end is always the last result of its item
    a_line_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_end |-> last)
        else $error("line_end without last");

    // an empty beat only closes a token or a line
    a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_char |-> token_end || line_end)
        else $error("empty result beat");

endmodule

bind shell_command_lexer scl_checker u_scl_checker (.*);

// ===== test/shell_command_lexer_tb.sv =====
`timescale 1ns / 1ps

module shell_command_lexer_tb;
    import scl_pkg::*;

    localparam int RANDOM_BEATS = 1200;
    localparam int HOLD_CYCLES  = 64;
    localparam int IDLE_PCT     = 34;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_NS     = 2_000_000;

    // one directed row: input byte plus the results typed in by hand
    typedef struct {
        logic [7:0] ch;
        logic       eoi;
        bit         typed;
        int         n;
        result_t    r0;
        result_t    r1;
    } lex_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] byte_in = 8'h00;
    logic       end_of_input = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_char;
    logic       has_char;
    logic       token_end;
    logic       line_end;
    logic       last;

    // lexer state mirrored by the predictor
    bit         in_sq;
    bit         in_dq;
    bit         esc_on;
    bit         cmt_on;
    bit         word_on;
    bit         op_on;
    logic [7:0] op_ch;
    result_t    step_res [2];
    int         step_n;

    result_t    expected_tokens [$];
    lex_row_t   lex_rows [$];

    int mismatches = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int line_ends = 0;
    int pair_items = 0;
    int input_stall_cycles = 0;
    int idle_pct = IDLE_PCT;
    int stall_pct = IDLE_PCT;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    result_t got_beat;
    result_t want_beat;

    shell_command_lexer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_in      (byte_in),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_char     (out_char),
        .has_char     (has_char),
        .token_end    (token_end),
        .line_end     (line_end),
        .last         (last)
    );

    always #5 clk = ~clk;

    function automatic result_t mk_beat(logic [7:0] c, logic has, logic te, logic le,
                                        logic lst);
        result_t r;
        r.out_char  = has ? c : 8'h00;
        r.has_char  = has;
        r.token_end = te;
        r.line_end  = le;
        r.last      = lst;
        return r;
    endfunction

    task push_res(input logic [7:0] c, input logic has, input logic te, input logic le);
        step_res[step_n] = mk_beat(c, has, te, le, 1'b0);
        step_n++;
    endtask

    // held operator goes out as a closed one-byte token
    task flush_op;
        if (op_on)
        begin
            push_res(op_ch, 1'b1, 1'b1, 1'b0);
            op_on = 1'b0;
            op_ch = 8'h00;
        end
    endtask

    // close whatever token is open
    task close_token;
        if (op_on)
            flush_op();
        else if (word_on)
        begin
            push_res(8'h00, 1'b0, 1'b1, 1'b0);
            word_on = 1'b0;
        end
    endtask

    task add_word(input logic [7:0] c);
        word_on = 1'b1;
        push_res(c, 1'b1, 1'b0, 1'b0);
    endtask

    // line end closes the open token and clears all state
    task finish_line;
        if (op_on)
            push_res(op_ch, 1'b1, 1'b1, 1'b1);
        else if (word_on)
            push_res(8'h00, 1'b0, 1'b1, 1'b1);
        else
            push_res(8'h00, 1'b0, 1'b0, 1'b1);
        in_sq   = 1'b0;
        in_dq   = 1'b0;
        esc_on  = 1'b0;
        cmt_on  = 1'b0;
        word_on = 1'b0;
        op_on   = 1'b0;
        op_ch   = 8'h00;
    endtask

    // token beats caused by one input byte
    task lex_beat(input logic [7:0] c, input logic eoi);
        step_n = 0;
        if (eoi)
            finish_line();
        else if (cmt_on)
        begin
            if (c == CH_NEWLINE)
                finish_line();
        end
        else if (esc_on)
        begin
            esc_on = 1'b0;
            add_word(c);
        end
        else if (in_sq)
        begin
            if (c == CH_SQUOTE)
                in_sq = 1'b0;
            else
                add_word(c);
        end
        else if (in_dq)
        begin
            if (c == CH_DQUOTE)
                in_dq = 1'b0;
            else if (c == CH_BSLASH)
                esc_on = 1'b1;
            else
                add_word(c);
        end
        else if (c == CH_NEWLINE)
            finish_line();
        else if (c == CH_HASH && !word_on && !op_on)
            cmt_on = 1'b1;
        else if (c == CH_BSLASH)
        begin
            flush_op();
            esc_on = 1'b1;
        end
        else if (c == CH_SQUOTE)
        begin
            flush_op();
            in_sq = 1'b1;
        end
        else if (c == CH_DQUOTE)
        begin
            flush_op();
            in_dq = 1'b1;
        end
        else if (c == CH_SPACE || c == CH_TAB)
            close_token();
        else if (c == CH_SEMI || c == CH_LT || c == CH_LPAREN || c == CH_RPAREN)
        begin
            close_token();
            push_res(c, 1'b1, 1'b1, 1'b0);
        end
        else if (c == CH_PIPE || c == CH_AMP || c == CH_GT)
        begin
            if (op_on)
            begin
                push_res(op_ch, 1'b1, 1'b0, 1'b0);
                push_res(c, 1'b1, 1'b1, 1'b0);
                op_on = 1'b0;
                op_ch = 8'h00;
            end
            else
            begin
                close_token();
                op_on = 1'b1;
                op_ch = c;
            end
        end
        else
        begin
            flush_op();
            add_word(c);
        end
        if (step_n > 0)
            step_res[step_n - 1].last = 1'b1;
    endtask

    task row(input logic [7:0] c, input logic eoi, input bit typed, input int n,
             input result_t r0, input result_t r1);
        lex_row_t v;
        v.ch    = c;
        v.eoi   = eoi;
        v.typed = typed;
        v.n     = n;
        v.r0    = r0;
        v.r1    = r1;
        lex_rows.push_back(v);
    endtask

    // offer one beat, wait for it to be taken, then queue what it should produce
    task send_beat(input logic [7:0] c, input logic eoi, input bit typed, input int n,
                   input result_t r0, input result_t r1);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            byte_in  <= 8'($urandom);
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        byte_in      <= c;
        end_of_input <= eoi;
        @(posedge clk);
        while (in_stall)
        begin
            input_stall_cycles++;
            @(posedge clk);
        end
        lex_beat(c, eoi);
        if (typed)
        begin
            if (n > 0)
                expected_tokens.push_back(r0);
            if (n > 1)
                expected_tokens.push_back(r1);
        end
        else
        begin
            for (int i = 0; i < step_n; i++)
                expected_tokens.push_back(step_res[i]);
        end
        if (step_n == 2)
            pair_items++;
        beats_sent++;
        @(negedge clk);
    endtask

    // random byte shaped like command-line text, with some noise
    task pick_byte(output logic [7:0] c, output logic eoi);
        int sel;
        sel = $urandom_range(99);
        eoi = 1'b0;
        if (sel < 28)
            c = 8'($urandom_range(8'h7A, 8'h61));
        else if (sel < 38)
            c = ($urandom_range(1)) ? CH_SPACE : CH_TAB;
        else if (sel < 50)
        begin
            case ($urandom_range(2))
                0:       c = CH_PIPE;
                1:       c = CH_AMP;
                default: c = CH_GT;
            endcase
        end
        else if (sel < 56)
        begin
            case ($urandom_range(3))
                0:       c = CH_SEMI;
                1:       c = CH_LT;
                2:       c = CH_LPAREN;
                default: c = CH_RPAREN;
            endcase
        end
        else if (sel < 62)
            c = ($urandom_range(1)) ? CH_SQUOTE : CH_DQUOTE;
        else if (sel < 66)
            c = CH_BSLASH;
        else if (sel < 71)
            c = CH_NEWLINE;
        else if (sel < 74)
            c = CH_HASH;
        else if (sel < 76)
        begin
            c   = 8'($urandom);
            eoi = 1'b1;
        end
        else
            c = 8'($urandom);
    endtask

    task note_mismatch(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected char %02h has %b te %b le %b last %b, got char %02h has %b te %b le %b last %b",
                     $time, what, want.out_char, want.has_char, want.token_end,
                     want.line_end, want.last, got.out_char, got.has_char,
                     got.token_end, got.line_end, got.last);
    endtask

    // receiver: random stalls, plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_go && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // compare each output beat with the oldest expected token beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_beat.out_char  = out_char;
            got_beat.has_char  = has_char;
            got_beat.token_end = token_end;
            got_beat.line_end  = line_end;
            got_beat.last      = last;
            if (expected_tokens.size() == 0)
                note_mismatch("unexpected beat", '0, got_beat);
            else
            begin
                want_beat = expected_tokens.pop_front();
                if (got_beat !== want_beat)
                    note_mismatch("beat mismatch", want_beat, got_beat);
                if (want_beat.line_end)
                    line_ends++;
            end
            beats_checked++;
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [7:0] c;
        logic       eoi;
        result_t    none;

        none = '0;
        in_sq = 1'b0; in_dq = 1'b0; esc_on = 1'b0; cmt_on = 1'b0;
        word_on = 1'b0; op_on = 1'b0; op_ch = 8'h00;

        // directed rows: extremes, every operator class, quotes, comments
        row(8'hFF, 1'b1, 1, 1, mk_beat(8'h00, 0, 0, 1, 1), none);
        row(8'h00, 1'b0, 1, 1, mk_beat(8'h00, 1, 0, 0, 1), none);
        row(8'hFF, 1'b0, 1, 1, mk_beat(8'hFF, 1, 0, 0, 1), none);
        row(CH_TAB, 1'b0, 1, 1, mk_beat(8'h00, 0, 1, 0, 1), none);
        row(CH_PIPE, 1'b0, 1, 0, none, none);
        row(CH_PIPE, 1'b0, 1, 2, mk_beat(CH_PIPE, 1, 0, 0, 0), mk_beat(CH_PIPE, 1, 1, 0, 1));
        row(CH_GT, 1'b0, 0, 0, none, none);
        row(8'h61, 1'b0, 0, 0, none, none);
        row(CH_HASH, 1'b0, 0, 0, none, none);
        row(CH_SPACE, 1'b0, 0, 0, none, none);
        row(CH_HASH, 1'b0, 0, 0, none, none);
        row(CH_SQUOTE, 1'b0, 0, 0, none, none);
        row(CH_NEWLINE, 1'b0, 1, 1, mk_beat(8'h00, 0, 0, 1, 1), none);
        row(CH_SQUOTE, 1'b0, 0, 0, none, none);
        row(CH_SQUOTE, 1'b0, 0, 0, none, none);
        row(CH_AMP, 1'b0, 0, 0, none, none);
        row(CH_DQUOTE, 1'b0, 0, 0, none, none);
        row(CH_NEWLINE, 1'b0, 0, 0, none, none);
        row(CH_BSLASH, 1'b0, 0, 0, none, none);
        row(CH_DQUOTE, 1'b0, 0, 0, none, none);
        row(CH_DQUOTE, 1'b0, 0, 0, none, none);
        row(CH_SEMI, 1'b0, 0, 0, none, none);
        row(CH_LPAREN, 1'b0, 0, 0, none, none);
        row(CH_RPAREN, 1'b0, 0, 0, none, none);
        row(CH_LT, 1'b0, 0, 0, none, none);
        row(CH_GT, 1'b0, 0, 0, none, none);
        row(CH_SQUOTE, 1'b0, 0, 0, none, none);
        row(8'h78, 1'b1, 0, 0, none, none);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (lex_rows[i])
            send_beat(lex_rows[i].ch, lex_rows[i].eoi, lex_rows[i].typed, lex_rows[i].n,
                      lex_rows[i].r0, lex_rows[i].r1);

        // random text; a quiet stretch in the middle, then a long receiver hold-off
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i == 300)
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            else if (i == 500)
            begin
                idle_pct  = IDLE_PCT;
                stall_pct = IDLE_PCT;
            end
            else if (i == 800)
                hold_go = 1'b1;
            pick_byte(c, eoi);
            send_beat(c, eoi, 0, 0, none, none);
        end
        in_valid <= 1'b0;

        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("lexed %0d input beats (%0d directed), checked %0d token beats, %0d line ends",
                 beats_sent, lex_rows.size(), beats_checked, line_ends);
        $display("%0d beats gave two results; %0d input stall cycles incl. a %0d-cycle hold-off",
                 pair_items, input_stall_cycles, HOLD_CYCLES);
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
